>>> rtl/srec_pkg.sv
package srec_pkg;

  // Largest payload a record may carry; the count byte runs from 3 to MaxData + 3.
  localparam int unsigned MaxData = 64;
  localparam logic [8:0] CountMax = 9'(MaxData + 3);
  localparam logic [8:0] CountMin = 9'd3;
  localparam logic [9:0] PosMax = 10'd1023;

  localparam logic [7:0] CharS  = 8'h53;
  localparam logic [7:0] Char0  = 8'h30;
  localparam logic [7:0] Char1  = 8'h31;
  localparam logic [7:0] Char9  = 8'h39;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharUa = 8'h41;
  localparam logic [7:0] CharUf = 8'h46;
  localparam logic [7:0] CharLa = 8'h61;
  localparam logic [7:0] CharLf_hex = 8'h66;

  typedef enum logic [0:0] {
    KindData   = 1'b0,
    KindStatus = 1'b1
  } srec_item_kind_e;

  typedef enum logic [1:0] {
    RecS0 = 2'd0,
    RecS1 = 2'd1,
    RecS9 = 2'd2
  } srec_rec_kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StMalformed = 2'd1,
    StChecksum  = 2'd2
  } srec_status_e;

  typedef struct packed {
    logic [0:0]  item_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] load_address;
    logic [1:0]  record_kind;
    logic [1:0]  status_code;
    logic [7:0]  payload_length;
    logic        final_item;
  } srec_result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } srec_nibble_t;

  function automatic srec_nibble_t decode_hex_char(input logic [7:0] c);
    srec_nibble_t n;
    n.valid = 1'b1;
    n.value = 4'd0;
    if (c >= Char0 && c <= Char9) begin
      n.value = 4'(c - Char0);
    end else if (c >= CharUa && c <= CharUf) begin
      n.value = 4'(c - CharUa + 8'd10);
    end else if (c >= CharLa && c <= CharLf_hex) begin
      n.value = 4'(c - CharLa + 8'd10);
    end else begin
      n.valid = 1'b0;
    end
    return n;
  endfunction

endpackage

>>> rtl/srec_if.sv
interface srec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

interface srec_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [15:0] load_address;
  logic [1:0]  record_kind;
  logic [1:0]  status_code;
  logic [7:0]  payload_length;
  logic        final_item;

  modport source (output valid, output item_kind, output data_byte, output byte_index,
                  output load_address, output record_kind, output status_code,
                  output payload_length, output final_item, input ready);
  modport sink (input valid, input item_kind, input data_byte, input byte_index,
                input load_address, input record_kind, input status_code,
                input payload_length, input final_item, output ready);
endinterface

>>> rtl/srec_parse.sv
module srec_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            char_code_i,
  input  logic                  end_of_line_i,
  output logic                  push0_o,
  output logic                  push1_o,
  output srec_pkg::srec_result_t res0_o,
  output srec_pkg::srec_result_t res1_o
);
  import srec_pkg::*;

  logic [9:0]  pos_q, pos_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [3:0]  hi_q, hi_d;
  logic [15:0] addr_q, addr_d;
  logic [1:0]  type_q, type_d;
  logic        mal_q, mal_d;
  logic        trail_q, trail_d;
  logic [7:0]  chk_q, chk_d;

  srec_nibble_t nib;
  logic [7:0]   v;
  logic [8:0]   b;
  logic         data_v;
  logic [7:0]   data_idx;
  logic [7:0]   plen;
  logic [10:0]  want_len;
  logic [1:0]   status;
  srec_result_t data_res, stat_res;

  always_comb begin
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    hi_d    = hi_q;
    addr_d  = addr_q;
    type_d  = type_q;
    mal_d   = mal_q;
    trail_d = trail_q;
    chk_d   = chk_q;
    data_v  = 1'b0;
    nib     = decode_hex_char(char_code_i);
    v       = {hi_q, nib.value};
    b       = pos_q[9:1] - 9'd1;
    data_idx = 8'(b - 9'd3);

    if (char_code_i == CharLf || char_code_i == CharCr) begin
      trail_d = 1'b1;
    end else if (trail_q) begin
      mal_d = 1'b1;
    end else begin
      if (pos_q != PosMax) begin
        pos_d = pos_q + 10'd1;
      end
      if (!mal_q) begin
        if (pos_q == 10'd0) begin
          if (char_code_i != CharS) mal_d = 1'b1;
        end else if (pos_q == 10'd1) begin
          case (char_code_i)
            Char0:   type_d = RecS0;
            Char1:   type_d = RecS1;
            Char9:   type_d = RecS9;
            default: mal_d = 1'b1;
          endcase
        end else if (!nib.valid) begin
          mal_d = 1'b1;
        end else if (!pos_q[0]) begin
          hi_d = nib.value;
        end else if (b == 9'd0) begin
          // count byte
          if ({1'b0, v} < CountMin || {1'b0, v} > CountMax) begin
            mal_d = 1'b1;
          end else begin
            cnt_d = v;
            sum_d = v;
          end
        end else if (b == 9'd1 || b == 9'd2) begin
          addr_d = {addr_q[7:0], v};
          sum_d  = sum_q + v;
        end else if (b < {1'b0, cnt_q}) begin
          sum_d  = sum_q + v;
          data_v = 1'b1;
        end else if (b == {1'b0, cnt_q}) begin
          chk_d = v;
        end else begin
          mal_d = 1'b1;
        end
      end
    end

    plen     = (cnt_d >= 8'd3) ? cnt_d - 8'd3 : 8'd0;
    want_len = 11'd4 + {2'b00, cnt_d, 1'b0};
    if (mal_d || cnt_d < 8'd3 || {1'b0, pos_d} != want_len) begin
      status = StMalformed;
    end else if (chk_d != ~sum_d) begin
      status = StChecksum;
    end else begin
      status = StOk;
    end

    data_res.item_kind      = KindData;
    data_res.data_byte      = v;
    data_res.byte_index     = data_idx;
    data_res.load_address   = addr_d;
    data_res.record_kind    = type_d;
    data_res.status_code    = StOk;
    data_res.payload_length = plen;
    data_res.final_item     = !end_of_line_i;

    stat_res.item_kind      = KindStatus;
    stat_res.data_byte      = 8'd0;
    stat_res.byte_index     = 8'd0;
    stat_res.load_address   = addr_d;
    stat_res.record_kind    = type_d;
    stat_res.status_code    = status;
    stat_res.payload_length = plen;
    stat_res.final_item     = 1'b1;

    if (data_v) begin
      res0_o  = data_res;
      res1_o  = stat_res;
      push0_o = accept_i;
      push1_o = accept_i && end_of_line_i;
    end else begin
      res0_o  = stat_res;
      res1_o  = stat_res;
      push0_o = accept_i && end_of_line_i;
      push1_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      hi_q    <= '0;
      addr_q  <= '0;
      type_q  <= '0;
      mal_q   <= 1'b0;
      trail_q <= 1'b0;
      chk_q   <= '0;
    end else if (accept_i) begin
      if (end_of_line_i) begin
        // line done: back to the reset state for the next line
        pos_q   <= '0;
        cnt_q   <= '0;
        sum_q   <= '0;
        hi_q    <= '0;
        addr_q  <= '0;
        type_q  <= '0;
        mal_q   <= 1'b0;
        trail_q <= 1'b0;
        chk_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
        hi_q    <= hi_d;
        addr_q  <= addr_d;
        type_q  <= type_d;
        mal_q   <= mal_d;
        trail_q <= trail_d;
        chk_q   <= chk_d;
      end
    end
  end

endmodule

>>> rtl/srec_res_queue.sv
module srec_res_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push0_i,
  input  logic                  push1_i,
  input  srec_pkg::srec_result_t res0_i,
  input  srec_pkg::srec_result_t res1_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output srec_pkg::srec_result_t res_o
);
  import srec_pkg::*;

  srec_result_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] wr_next;
  logic [1:0] n_push;
  logic       pop;

  assign wr_next = wr_q + 2'd1;
  assign n_push  = {1'b0, push0_i} + {1'b0, push1_i};
  assign pop     = pop_i && valid_o;
  assign valid_o = cnt_q != 3'd0;
  // room for the two results one item can cause
  assign space_o = cnt_q <= 3'd2;
  assign res_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= res0_i;
    if (push1_i) mem_q[wr_next] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop};
    end
  end

endmodule

>>> rtl/srec_record_decoder.sv
// S-record line decoder for S0/S1/S9 records with a 16-bit address. Characters of one line
// enter one per cycle on in_i while it is ready, the last one flagged by end_of_line; the
// decoder then returns to its reset state for the next line. Every completed data byte comes
// out as a data item, and the flagged character adds a status item (ok, malformed, checksum
// mismatch), so a character causes at most two items. Each character is decoded
// combinationally against the line state registers and its items go into a four-entry
// result queue; in_i is ready whenever that queue has room for two items, so one character
// per cycle is sustained while out_o drains, and results leave the queue on out_o in order.
module srec_record_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  srec_in_if.sink    in_i,
  srec_out_if.source out_o
);
  import srec_pkg::*;

  logic         accept;
  logic         push0, push1;
  logic         space;
  srec_result_t res0, res1, head;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  srec_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_code_i  (in_i.char_code),
    .end_of_line_i(in_i.end_of_line),
    .push0_o      (push0),
    .push1_o      (push1),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  srec_res_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(push0),
    .push1_i(push1),
    .res0_i (res0),
    .res1_i (res1),
    .space_o(space),
    .valid_o(out_o.valid),
    .pop_i  (out_o.ready),
    .res_o  (head)
  );

  assign out_o.item_kind      = head.item_kind;
  assign out_o.data_byte      = head.data_byte;
  assign out_o.byte_index     = head.byte_index;
  assign out_o.load_address   = head.load_address;
  assign out_o.record_kind    = head.record_kind;
  assign out_o.status_code    = head.status_code;
  assign out_o.payload_length = head.payload_length;
  assign out_o.final_item     = head.final_item;

endmodule
